>>> hdl/beq_pkg.sv
// ----------------------------------------------------------------------------
// beq_pkg
// Shared types and constants of the cascaded biquad equalizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package beq_pkg;

    // Fixed widths of the item fields and delay state, and coefficients per band
    localparam int COEF_BITS      = 32;
    localparam int COEFS_PER_BAND = 5;
    localparam int DELAY_BITS     = 48;
    localparam int BAND_SEL_BITS  = 3;
    localparam int COEF_SEL_BITS  = 3;

    // Item kinds
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    // Coefficient slots of one band, in store order
    typedef enum logic [2:0] {
        C_B0  = 3'd0,
        C_B1  = 3'd1,
        C_B2  = 3'd2,
        C_NA1 = 3'd3,
        C_NA2 = 3'd4
    } t_coef;

    // Tag that travels with a coefficient read through the datapath
    typedef struct packed {
        logic  vld;
        t_coef k;
    } t_tag;

endpackage

>>> hdl/beq_if.sv
// ----------------------------------------------------------------------------
// beq_if
// Valid/ready channels of the equalizer: input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface beq_in_if #(
    parameter int SAMPLE_BITS = 24
);
    import beq_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          block_end_in;
    logic [BAND_SEL_BITS-1:0]      band_sel;
    logic [COEF_SEL_BITS-1:0]      coef_sel;
    logic signed [COEF_BITS-1:0]   coef_value;

    modport source (
        output valid, mode, sample_in, block_end_in, band_sel, coef_sel, coef_value,
        input  ready
    );

    modport sink (
        input  valid, mode, sample_in, block_end_in, band_sel, coef_sel, coef_value,
        output ready
    );
endinterface

interface beq_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          block_end_out;

    modport source (
        output valid, sample_out, block_end_out,
        input  ready
    );

    modport sink (
        input  valid, sample_out, block_end_out,
        output ready
    );
endinterface

>>> hdl/cascaded_biquad_equalizer.sv
// ----------------------------------------------------------------------------
// cascaded_biquad_equalizer
// Sample items are processed one at a time: the input is ready only while idle
// and is ready again as the result goes valid.
// Reset: coefficients flat (b0 one), delays zero, enable set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cascaded_biquad_equalizer #(
    parameter int BANDS          = 6,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    beq_in_if.sink      i_item,
    beq_out_if.source   o_result
);
    import beq_pkg::*;

    localparam int BW = $clog2(BANDS > 1 ? BANDS : 2);
    localparam int CW = $clog2(BANDS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic [CW-1:0]                 r_band;
    logic [CW-1:0]                 n_band;
    t_coef                         r_k;
    t_coef                         n_k;
    logic                          r_enable;
    logic                          r_blk;
    logic                          r_out_vld;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_blk;

    logic                          in_acc;
    logic                          smp_acc;
    logic                          coef_wr;
    logic                          band_live;
    logic                          flat;
    logic                          done;
    logic                          out_take;
    logic                          mac_busy;
    t_tag                          issue;
    t_tag                          rd_tag;
    logic [BW-1:0]                 rd_band;
    logic signed [COEF_BITS-1:0]   coef;
    logic signed [SAMPLE_BITS-1:0] x;

    // handshake decode
    always_comb begin
        in_acc    = i_item.valid && i_item.ready;
        smp_acc   = in_acc && (i_item.mode == MODE_SAMPLE);
        coef_wr   = in_acc && (i_item.mode == MODE_COEF);
        band_live = (r_band != CW'(BANDS));
        issue.vld = (r_state == S_RUN) && band_live && !flat;
        issue.k   = r_k;
        out_take  = r_out_vld && o_result.ready;
        done      = (r_state == S_DRAIN) && !mac_busy && (!r_out_vld || o_result.ready);
    end

    // sequencer: walk bands and coefficient slots, skip flat bands
    always_comb begin
        n_state = r_state;
        n_band  = r_band;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (smp_acc) begin
                    n_band  = '0;
                    n_k     = C_B0;
                    n_state = r_enable ? S_RUN : S_DRAIN;
                end
            end
            S_RUN: begin
                if (!band_live) begin
                    n_state = S_DRAIN;
                end else if (flat) begin
                    n_band = r_band + CW'(1);
                end else if (r_k == C_NA2) begin
                    n_k    = C_B0;
                    n_band = r_band + CW'(1);
                end else begin
                    n_k = t_coef'(r_k + 3'd1);
                end
            end
            S_DRAIN: begin
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_band    <= '0;
            r_k       <= C_B0;
            r_enable  <= 1'b1;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_band  <= n_band;
            r_k     <= n_k;
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if (done) begin
                r_out_vld <= 1'b1;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // item payload and output register
    always_ff @(posedge i_clk) begin
        if (smp_acc) begin
            r_blk <= i_item.block_end_in;
        end
        if (done) begin
            r_out_sample <= x;
            r_out_blk    <= r_blk;
        end
    end

    beq_coef #(
        .BANDS          (BANDS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (coef_wr),
        .i_wr_band   (i_item.band_sel),
        .i_wr_sel    (i_item.coef_sel),
        .i_wr_value  (i_item.coef_value),
        .i_rd_tag    (issue),
        .i_rd_band   (r_band[BW-1:0]),
        .o_tag       (rd_tag),
        .o_band      (rd_band),
        .o_coef      (coef),
        .i_flat_band (r_band[BW-1:0]),
        .o_flat      (flat)
    );

    beq_mac #(
        .BANDS          (BANDS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (rd_tag),
        .i_band   (rd_band),
        .i_coef   (coef),
        .i_load   (smp_acc),
        .i_sample (i_item.sample_in),
        .o_x      (x),
        .o_busy   (mac_busy)
    );

    assign i_item.ready           = (r_state == S_IDLE);
    assign o_result.valid         = r_out_vld;
    assign o_result.sample_out    = r_out_sample;
    assign o_result.block_end_out = r_out_blk;

endmodule

>>> hdl/beq_ram.sv
// ----------------------------------------------------------------------------
// beq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module beq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 30
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/beq_coef.sv
// ----------------------------------------------------------------------------
// beq_coef
// Coefficient store: RAM plus per-entry written and flat-match bits.
// Unwritten entries read as the flat reset value (b0 one, others zero).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module beq_coef #(
    parameter int BANDS          = 6,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // write side
    input  logic                                     i_wr_en,
    input  logic [beq_pkg::BAND_SEL_BITS-1:0]        i_wr_band,
    input  logic [beq_pkg::COEF_SEL_BITS-1:0]        i_wr_sel,
    input  logic signed [beq_pkg::COEF_BITS-1:0]     i_wr_value,
    // read side
    input  beq_pkg::t_tag                            i_rd_tag,
    input  logic [$clog2(BANDS > 1 ? BANDS : 2)-1:0] i_rd_band,
    output beq_pkg::t_tag                            o_tag,
    output logic [$clog2(BANDS > 1 ? BANDS : 2)-1:0] o_band,
    output logic signed [beq_pkg::COEF_BITS-1:0]     o_coef,
    // flat query
    input  logic [$clog2(BANDS > 1 ? BANDS : 2)-1:0] i_flat_band,
    output logic                                     o_flat
);
    import beq_pkg::*;

    localparam int BW    = $clog2(BANDS > 1 ? BANDS : 2);
    localparam int NCOEF = BANDS * COEFS_PER_BAND;
    localparam int AW    = $clog2(NCOEF);
    localparam int IXW   = AW + 3;
    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

    logic [NCOEF-1:0]             r_written;
    logic [NCOEF-1:0]             r_match;
    t_tag                         r_tag;
    logic [BW-1:0]                r_band;
    logic                         r_rd_written;
    logic [IXW-1:0]               wr_ix;
    logic [IXW-1:0]               rd_ix;
    logic [IXW-1:0]               fl_ix;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                rd_addr;
    logic                         wr_ok;
    logic signed [COEF_BITS-1:0]  wr_default;
    logic [COEF_BITS-1:0]         ram_q;

    // address decode: entry = band * 5 + slot
    always_comb begin
        wr_ix      = IXW'(i_wr_band) * IXW'(COEFS_PER_BAND) + IXW'(i_wr_sel);
        rd_ix      = IXW'(i_rd_band) * IXW'(COEFS_PER_BAND) + IXW'(i_rd_tag.k);
        fl_ix      = IXW'(i_flat_band) * IXW'(COEFS_PER_BAND);
        wr_addr    = wr_ix[AW-1:0];
        rd_addr    = rd_ix[AW-1:0];
        wr_ok      = i_wr_en && (32'(i_wr_band) < BANDS) && (32'(i_wr_sel) < COEFS_PER_BAND);
        wr_default = (i_wr_sel == COEF_SEL_BITS'(C_B0)) ? COEF_ONE : '0;
    end

    // band is flat when all five of its entries hold the flat value
    assign o_flat = &r_match[fl_ix[AW-1:0] +: COEFS_PER_BAND];

    beq_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (NCOEF)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_ok),
        .i_waddr (wr_addr),
        .i_wdata (i_wr_value),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // control: entry status bits and read tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_match   <= '1;
            r_tag     <= '0;
        end else begin
            if (wr_ok) begin
                r_written[wr_addr] <= 1'b1;
                r_match[wr_addr]   <= (i_wr_value == wr_default);
            end
            r_tag <= i_rd_tag;
        end
    end

    // read side payload, aligned with the RAM output
    always_ff @(posedge i_clk) begin
        r_band       <= i_rd_band;
        r_rd_written <= r_written[rd_addr];
    end

    assign o_tag  = r_tag;
    assign o_band = r_band;
    assign o_coef = r_rd_written ? signed'(ram_q)
                                 : ((r_tag.k == C_B0) ? COEF_ONE : '0);

endmodule

>>> hdl/beq_mac.sv
// ----------------------------------------------------------------------------
// beq_mac
// Shared multiply / round / accumulate unit with the biquad delay state.
// Tags from the coefficient store steer each product to its destination.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module beq_mac #(
    parameter int BANDS          = 6,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  beq_pkg::t_tag                            i_tag,
    input  logic [$clog2(BANDS > 1 ? BANDS : 2)-1:0] i_band,
    input  logic signed [beq_pkg::COEF_BITS-1:0]     i_coef,
    input  logic                                     i_load,
    input  logic signed [SAMPLE_BITS-1:0]            i_sample,
    output logic signed [SAMPLE_BITS-1:0]            o_x,
    output logic                                     o_busy
);
    import beq_pkg::*;

    localparam int BW = $clog2(BANDS > 1 ? BANDS : 2);
    localparam int DF = ((43 - SAMPLE_BITS) < COEF_FRAC_BITS) ? (43 - SAMPLE_BITS)
                                                             : COEF_FRAC_BITS;
    localparam int PS = COEF_FRAC_BITS - DF;
    localparam int PW = COEF_BITS + SAMPLE_BITS;
    localparam int AW = PW + 2;
    localparam logic signed [AW-1:0] HALF_P = (AW'(1) << PS) >> 1;
    localparam logic signed [AW-1:0] HALF_Y = (AW'(1) << DF) >> 1;
    localparam logic signed [AW-1:0] YMAX   = (AW'(1) << (SAMPLE_BITS - 1)) - AW'(1);
    localparam logic signed [AW-1:0] YMIN   = ~YMAX;
    localparam logic signed [AW-1:0] DMAX   = (AW'(1) << (DELAY_BITS - 1)) - AW'(1);
    localparam logic signed [AW-1:0] DMIN   = ~DMAX;

    logic signed [PW-1:0]          r_prod;
    t_tag                          r_pr_tag;
    logic [BW-1:0]                 r_pr_band;
    logic signed [AW-1:0]          r_acc_y;
    logic signed [AW-1:0]          r_acc1;
    logic signed [AW-1:0]          r_acc2;
    logic                          r_ys_vld;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [DELAY_BITS-1:0]  r_s1 [BANDS];
    logic signed [DELAY_BITS-1:0]  r_s2 [BANDS];

    logic signed [AW-1:0]          rnd;
    logic signed [AW-1:0]          s1_cur;
    logic signed [AW-1:0]          s2_cur;
    logic signed [AW-1:0]          sum1;
    logic signed [AW-1:0]          sum2;
    logic signed [AW-1:0]          y_rnd;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    function automatic logic signed [DELAY_BITS-1:0] sat_delay(
        input logic signed [AW-1:0] v
    );
        logic signed [AW-1:0] c;
        c = (v > DMAX) ? DMAX : ((v < DMIN) ? DMIN : v);
        return c[DELAY_BITS-1:0];
    endfunction

    // product rounding, delay sums and band output
    always_comb begin
        rnd    = (AW'(r_prod) + HALF_P) >>> PS;
        s1_cur = AW'(r_s1[r_pr_band]);
        s2_cur = AW'(r_s2[r_pr_band]);
        sum1   = r_acc1 + rnd;
        sum2   = r_acc2 + rnd;
        y_rnd  = (r_acc_y + HALF_Y) >>> DF;
        if (y_rnd > YMAX) begin
            y_sat = YMAX[SAMPLE_BITS-1:0];
        end else if (y_rnd < YMIN) begin
            y_sat = YMIN[SAMPLE_BITS-1:0];
        end else begin
            y_sat = y_rnd[SAMPLE_BITS-1:0];
        end
    end

    // control: stage valids and delay state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr_tag <= '0;
            r_ys_vld <= 1'b0;
            for (int b = 0; b < BANDS; b++) begin
                r_s1[b] <= '0;
                r_s2[b] <= '0;
            end
        end else begin
            r_pr_tag <= i_tag;
            r_ys_vld <= r_pr_tag.vld && (r_pr_tag.k == C_B0);
            if (r_pr_tag.vld && (r_pr_tag.k == C_NA1)) begin
                r_s1[r_pr_band] <= sat_delay(sum1);
            end
            if (r_pr_tag.vld && (r_pr_tag.k == C_NA2)) begin
                r_s2[r_pr_band] <= sat_delay(sum2);
            end
        end
    end

    // datapath: multiply, accumulate, running sample
    always_ff @(posedge i_clk) begin
        r_prod    <= PW'(i_coef) * PW'(r_x);
        r_pr_band <= i_band;
        if (r_pr_tag.vld) begin
            unique case (r_pr_tag.k)
                C_B0:    r_acc_y <= rnd + s1_cur;
                C_B1:    r_acc1  <= rnd + s2_cur;
                C_B2:    r_acc2  <= rnd;
                C_NA1,
                C_NA2:   ;
                default: ;
            endcase
        end
        // x feeds b0..b2 of a band, then takes that band's y for na1, na2 and the next band
        if (i_load) begin
            r_x <= i_sample;
        end else if (r_ys_vld) begin
            r_x <= y_sat;
        end
    end

    assign o_x    = r_x;
    assign o_busy = i_tag.vld | r_pr_tag.vld | r_ys_vld;

endmodule
